FILE: rtl/spq_pkg.sv
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; imported by spq_ctrl, the top level and the testbench.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CODE_W = 32;
	localparam int PRIO_W = 8;
	localparam int STATUS_W = 2;
	localparam int ENTRY_COUNT_W = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [PRIO_W-1:0] prio_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ENTRY_COUNT_W-1:0] entry_count_t;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam status_t ST_DONE = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	typedef struct packed {
		code_t code;
		prio_t prio;
	} spq_entry_t;

	typedef struct packed {
		logic mode;
		code_t code;
		prio_t prio;
	} spq_req_t;

	typedef struct packed {
		code_t code;
		prio_t prio;
		status_t status;
		entry_count_t entry_count;
	} spq_result_t;

endpackage

FILE: rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/spq_ctrl.sv
// Sequencer for the sorted store: one priority compare per cycle while shifting.
// Depends on spq_pkg; drives the ports of one spq_ram.
// Storage order is reversed: the front task sits at address count-1.
module spq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input spq_pkg::spq_req_t req,
	input logic out_free,
	output logic busy,
	output logic done,
	output spq_pkg::spq_result_t res,
	output logic rd_en,
	output spq_pkg::idx_t rd_addr,
	input spq_pkg::spq_entry_t rd_data,
	output logic wr_en,
	output spq_pkg::idx_t wr_addr,
	output spq_pkg::spq_entry_t wr_data
);
	import spq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_RDREM = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q, state_d;
	cnt_t count_q, count_d;
	idx_t idx_q, idx_d;
	spq_entry_t new_q, new_d;
	code_t res_code_q, res_code_d;
	prio_t res_prio_q, res_prio_d;
	status_t res_status_q, res_status_d;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		new_d = new_q;
		res_code_d = res_code_q;
		res_prio_d = res_prio_q;
		res_status_d = res_status_q;
		rd_en = 1'b0;
		rd_addr = idx_q - 1'b1;
		wr_en = 1'b0;
		wr_addr = idx_q + 1'b1;
		wr_data = rd_data;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					new_d = '{code: req.code, prio: req.prio};
					res_code_d = '0;
					res_prio_d = '0;
					res_status_d = ST_DONE;
					if (req.mode == MODE_REMOVE) begin
						if (count_q == '0) begin
							res_status_d = ST_EMPTY;
							state_d = S_FIN;
						end else begin
							rd_en = 1'b1;
							rd_addr = IDX_W'(count_q - 1'b1);
							state_d = S_RDREM;
						end
					end else begin
						if (count_q == CNT_W'(CAPACITY)) begin
							res_status_d = ST_FULL;
							state_d = S_FIN;
						end else if (count_q == '0) begin
							wr_en = 1'b1;
							wr_addr = '0;
							wr_data = '{code: req.code, prio: req.prio};
							count_d = CNT_W'(1);
							state_d = S_FIN;
						end else begin
							// scan from the front (top address) down
							rd_en = 1'b1;
							rd_addr = IDX_W'(count_q - 1'b1);
							idx_d = IDX_W'(count_q - 1'b1);
							state_d = S_CMP;
						end
					end
				end
			end
			S_CMP: begin
				wr_en = 1'b1;
				if (rd_data.prio > new_q.prio) begin
					// stored task is served earlier: move it up one slot
					wr_data = rd_data;
					if (idx_q == '0) begin
						state_d = S_PLACE;
					end else begin
						rd_en = 1'b1;
						idx_d = idx_q - 1'b1;
					end
				end else begin
					wr_data = new_q;
					count_d = count_q + 1'b1;
					state_d = S_FIN;
				end
			end
			S_PLACE: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = new_q;
				count_d = count_q + 1'b1;
				state_d = S_FIN;
			end
			S_RDREM: begin
				res_code_d = rd_data.code;
				res_prio_d = rd_data.prio;
				count_d = count_q - 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		new_q <= new_d;
		res_code_q <= res_code_d;
		res_prio_q <= res_prio_d;
		res_status_q <= res_status_d;
	end

	assign busy = (state_q != S_IDLE);
	assign res = '{
		code: res_code_q,
		prio: res_prio_q,
		status: res_status_q,
		entry_count: ENTRY_COUNT_W'(count_q)
	};

endmodule

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: handshakes, output register, store.
// Depends on spq_pkg, spq_ram and spq_ctrl.
//
//  channel | signals                                  | dir | accepted when
//  --------+------------------------------------------+-----+--------------------------
//  input   | in_valid, in_stall, mode, task_code,     | in  | in_valid && !in_stall
//          | task_priority                            |     |
//  output  | out_valid, out_stall, out_code,          | out | out_valid && !out_stall
//          | out_priority, status, entry_count        |     |
//
// Remove reads the front task. Insert moves each stored task with a higher
// priority up one slot, one priority compare per cycle against the RAM read port.
// Insert into an empty store, full or empty errors: no scan, straight to the result.
// in_stall is high while an item is in work.
// Reset empties the store at once; the RAM itself is not cleared.
// A held result does not block the next item; only the one after waits.
module sorted_priority_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input spq_pkg::code_t task_code,
	input spq_pkg::prio_t task_priority,
	output logic out_valid,
	input logic out_stall,
	output spq_pkg::code_t out_code,
	output spq_pkg::prio_t out_priority,
	output spq_pkg::status_t status,
	output spq_pkg::entry_count_t entry_count
);
	import spq_pkg::*;

	logic busy;
	logic done;
	logic out_free;
	logic start;
	spq_req_t req;
	spq_result_t res;
	spq_result_t out_q;
	logic out_valid_q;
	logic rd_en;
	logic wr_en;
	idx_t rd_addr;
	idx_t wr_addr;
	spq_entry_t rd_data;
	spq_entry_t wr_data;

	assign in_stall = busy;
	assign start = in_valid && !busy;
	assign req = '{mode: mode, code: task_code, prio: task_priority};
	assign out_free = !out_valid_q || !out_stall;

	spq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.out_free(out_free),
		.busy(busy),
		.done(done),
		.res(res),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	spq_ram #(
		.WIDTH($bits(spq_entry_t)),
		.DEPTH(CAPACITY)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_code = out_q.code;
	assign out_priority = out_q.prio;
	assign status = out_q.status;
	assign entry_count = out_q.entry_count;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer idle right after accepting an item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_code) && $stable(status))
		else $error("held result lost or changed");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == ENTRY_COUNT_W'(CAPACITY)
			&& out_code == '0)
		else $error("full status with store not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0 && out_priority == '0)
		else $error("empty status with tasks stored");

endmodule

FILE: verif/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: directed and random insert/remove traffic
// with random gaps and output stalls, checked against an in-bench model of the sorted store.
// Depends on rtl/spq_pkg.sv and rtl/sorted_priority_queue.sv.
module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int RANDOM_ITEMS = 430;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	code_t task_code;
	prio_t task_priority;
	logic out_valid;
	logic out_stall;
	code_t out_code;
	prio_t out_priority;
	status_t status;
	entry_count_t entry_count;

	sorted_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.task_code(task_code),
		.task_priority(task_priority),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_code(out_code),
		.out_priority(out_priority),
		.status(status),
		.entry_count(entry_count)
	);

	// model of the store, kept in serving order
	code_t model_codes[CAPACITY];
	prio_t model_prios[CAPACITY];
	int model_held = 0;

	spq_result_t expected_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int inserts_done = 0;
	int removes_done = 0;
	int full_rejects = 0;
	int empty_rejects = 0;
	int peak_held = 0;

	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic spq_result_t predict_queue_step(input logic op, input code_t code,
			input prio_t prio);
		spq_result_t r;
		int pos;
		r = '0;
		r.status = ST_DONE;
		if (op == MODE_INSERT) begin
			if (model_held >= CAPACITY) begin
				r.status = ST_FULL;
				full_rejects++;
			end else begin
				pos = 0;
				while (pos < model_held && model_prios[pos] > prio)
					pos++;
				for (int i = model_held; i > pos; i--) begin
					model_codes[i] = model_codes[i-1];
					model_prios[i] = model_prios[i-1];
				end
				model_codes[pos] = code;
				model_prios[pos] = prio;
				model_held++;
				inserts_done++;
				if (model_held > peak_held)
					peak_held = model_held;
			end
		end else if (model_held == 0) begin
			r.status = ST_EMPTY;
			empty_rejects++;
		end else begin
			r.code = model_codes[0];
			r.prio = model_prios[0];
			for (int i = 1; i < model_held; i++) begin
				model_codes[i-1] = model_codes[i];
				model_prios[i-1] = model_prios[i];
			end
			model_held--;
			removes_done++;
		end
		r.entry_count = entry_count_t'(model_held);
		return r;
	endfunction

	function automatic code_t random_code();
		code_t c;
		if ($urandom_range(0, 1)) begin
			c = $urandom;
		end else begin
			// printable task names
			for (int b = 0; b < 4; b++)
				c[b*8 +: 8] = 8'($urandom_range(8'h30, 8'h5a));
		end
		return c;
	endfunction

	task automatic send_item(input logic op, input code_t code, input prio_t prio);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		task_code <= code;
		task_priority <= prio;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_results.push_back(predict_queue_step(op, code, prio));
		items_sent++;
	endtask

	// hold the input idle until every expected result has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_remove();
		send_item(MODE_REMOVE, random_code(), prio_t'($urandom));
		send_item(MODE_REMOVE, '1, '1);
	endtask

	task automatic test_field_extremes();
		send_item(MODE_INSERT, 32'hffff_ffff, 8'hff);
		send_item(MODE_INSERT, 32'h0000_0000, 8'h00);
		send_item(MODE_INSERT, 32'ha5a5_a5a5, 8'h80);
		send_item(MODE_INSERT, 32'h5a5a_5a5a, 8'h7f);
		repeat (4) send_item(MODE_REMOVE, random_code(), prio_t'($urandom));
		send_item(MODE_REMOVE, 32'h0, 8'h0);
	endtask

	// equal priorities come out newest first
	task automatic test_tie_order();
		send_item(MODE_INSERT, "TSK1", 8'd7);
		send_item(MODE_INSERT, "TSK2", 8'd7);
		send_item(MODE_INSERT, "LOW1", 8'd6);
		send_item(MODE_INSERT, "TSK3", 8'd7);
		send_item(MODE_INSERT, "TOP1", 8'd8);
		repeat (5) send_item(MODE_REMOVE, random_code(), prio_t'($urandom));
	endtask

	// phases lean toward inserts (runs into full), removes (runs dry) or neither
	task automatic test_random_traffic(input int total);
		int phase;
		int phase_len;
		int pick;
		logic op;
		prio_t prio;
		bit drained;
		phase = 0;
		drained = 1'b0;
		while (items_sent < total) begin
			phase_len = $urandom_range(30, 50);
			sender_gaps_on = ($urandom_range(0, 3) != 0);
			receiver_stalls_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < phase_len && items_sent < total; n++) begin
				pick = $urandom_range(0, 99);
				case (phase % 3)
					0: op = (pick < 15) ? MODE_REMOVE : MODE_INSERT;
					1: op = (pick < 85) ? MODE_REMOVE : MODE_INSERT;
					default: op = (pick < 50) ? MODE_REMOVE : MODE_INSERT;
				endcase
				pick = $urandom_range(0, 3);
				case (pick)
					0, 1: prio = prio_t'($urandom_range(0, 3));
					2: prio = prio_t'($urandom);
					default: prio = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
				endcase
				send_item(op, random_code(), prio);
			end
			if (!drained && phase == 3) begin
				drain_results();
				drained = 1'b1;
			end
			phase++;
		end
	endtask

	always @(posedge clk) begin
		spq_result_t got;
		spq_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{out_code, out_priority, status, entry_count};
			results_seen++;
			stall_left <= receiver_stalls_on ? $urandom_range(0, 12) : 0;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: code %h prio %0d status %0d count %0d",
						$realtime, got.code, got.prio, got.status, got.entry_count);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: exp code %h prio %0d status %0d count %0d, got code %h prio %0d status %0d count %0d",
							$realtime, want.code, want.prio, want.status, want.entry_count,
							got.code, got.prio, got.status, got.entry_count);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
				$display("tb_sorted_priority_queue: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int errors;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		task_code = '0;
		task_priority = '0;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_remove();
		test_field_extremes();
		test_tie_order();
		test_random_traffic(items_sent + RANDOM_ITEMS);

		drain_results();
		repeat (40) @(posedge clk);
		errors = mismatches + expected_results.size();
		$display("%0d items, %0d results: %0d inserts, %0d removes, peak fill %0d of %0d",
			items_sent, results_seen, inserts_done, removes_done, peak_held, CAPACITY);
		$display("rejected: %0d inserts into a full store, %0d removes from an empty one",
			full_rejects, empty_rejects);
		if (errors == 0)
			$display("tb_sorted_priority_queue: done, clean");
		else
			$display("tb_sorted_priority_queue: done, errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
